/* rtl/irprop_pkg.sv */
// ---------------------------------------------------------------------------
// irprop_pkg
// Shared types and constants for the iRPROP- weight update block.
// ---------------------------------------------------------------------------
package irprop_pkg;

  localparam int WEIGHT_COUNT = 1024;
  localparam int INDEX_W      = $clog2(WEIGHT_COUNT);
  localparam int CLR_W        = $clog2(WEIGHT_COUNT + 1);

  // config register indexes
  localparam int CFG_INDEX_W = 2;
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INCREASE = 2'd0,
    CFG_DECREASE = 2'd1,
    CFG_FLOOR    = 2'd2,
    CFG_CEILING  = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] INCREASE_RESET = 16'd19661;
  localparam logic [15:0] DECREASE_RESET = 16'd8192;
  localparam logic [31:0] FLOOR_RESET    = 32'd1;
  localparam logic [31:0] CEILING_RESET  = 32'd3276800;
  localparam logic [31:0] STEP_RESET     = 32'd6554;

  // stored gradient sign codes
  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;

  // rounding of the Q2.14 factor product
  localparam int          FRAC_W    = 14;
  localparam logic [48:0] ROUND_ADD = 49'd8192;

  typedef enum logic [1:0] {
    OP_KEEP,
    OP_GROW,
    OP_SHRINK
  } step_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic [INDEX_W-1:0] weight_index;
    logic signed [31:0] gradient;
    logic signed [31:0] weight_in;
  } grad_beat_t;

  typedef struct packed {
    logic signed [31:0] weight_out;
    logic [31:0]        step_used;
  } upd_beat_t;

  // memory word: sign code over step size
  typedef struct packed {
    logic [1:0]  sign;
    logic [31:0] step;
  } entry_t;

endpackage

/* rtl/irprop_minus_update.sv */
// ---------------------------------------------------------------------------
// irprop_minus_update
// iRPROP- weight update: per-weight step adaptation held in one memory.
// ---------------------------------------------------------------------------
// Usage
//   grad channel: one beat per weight (index, gradient, weight), accepted
//   when grad_valid is high and grad_stall low.
//   upd channel: one beat per accepted grad beat (new weight, step used),
//   taken when upd_valid is high and upd_stall low; beats keep order.
//   cfg port: write-only, cfg_write strobes cfg_data into register
//   cfg_index (0 increase, 1 decrease, 2 floor, 3 ceiling). Write only
//   while no beat is in flight.
// Timing
//   An item passes from accept to upd_valid through these steps: memory
//   read at the accept edge, then factor multiply, round and clamp, and
//   weight update with write-back, which loads the output register.
//   A new item is accepted only after the last one's write-back, since the
//   state memory is read, modified and written for a single item at a time.
//   The output register lets the next item be accepted while a result
//   waits; if upd_stall holds, the item after it waits in its last step.
// Reset
//   rst (synchronous) restores the config defaults, then a clearing pass
//   writes every entry (sign zero, step 0.1); grad_stall stays high
//   throughout. Config writes are taken during the pass.
// ---------------------------------------------------------------------------
module irprop_minus_update (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                grad_valid,
  output logic                                grad_stall,
  input  irprop_pkg::grad_beat_t              grad_beat,
  output logic                                upd_valid,
  input  logic                                upd_stall,
  output irprop_pkg::upd_beat_t               upd_beat,
  input  logic                                cfg_write,
  input  logic [irprop_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                         cfg_data
);

  // config registers
  logic [15:0] increase_factor;
  logic [15:0] decrease_factor;
  logic [31:0] step_floor;
  logic [31:0] step_ceiling;

  always_ff @(posedge clk) begin
    if (rst) begin
      increase_factor <= irprop_pkg::INCREASE_RESET;
      decrease_factor <= irprop_pkg::DECREASE_RESET;
      step_floor      <= irprop_pkg::FLOOR_RESET;
      step_ceiling    <= irprop_pkg::CEILING_RESET;
    end else if (cfg_write) begin
      unique case (irprop_pkg::cfg_reg_t'(cfg_index))
        irprop_pkg::CFG_INCREASE: increase_factor <= cfg_data[15:0];
        irprop_pkg::CFG_DECREASE: decrease_factor <= cfg_data[15:0];
        irprop_pkg::CFG_FLOOR:    step_floor      <= cfg_data;
        irprop_pkg::CFG_CEILING:  step_ceiling    <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  irprop_pkg::state_t state, state_next;
  logic [irprop_pkg::CLR_W-1:0] clr_cnt;

  // control strobes
  logic accept;
  logic mem_we;
  logic out_load;
  logic [irprop_pkg::INDEX_W-1:0] mem_waddr;
  irprop_pkg::entry_t             mem_wdata;

  // per-item pipeline registers
  irprop_pkg::grad_beat_t item_q;
  irprop_pkg::entry_t     mem_q;
  irprop_pkg::step_op_t   op_q;
  logic                   in_range_q;
  logic                   gpos_q;      // effective gradient sign after shrink
  logic                   gneg_q;
  logic [47:0]            prod_q;
  logic [31:0]            delta_q;

  irprop_pkg::entry_t mem [irprop_pkg::WEIGHT_COUNT];

  assign accept = grad_valid && !grad_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irprop_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == irprop_pkg::ST_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    grad_stall = 1'b1;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    mem_waddr  = item_q.weight_index;
    mem_wdata  = '{sign: irprop_pkg::SIGN_ZERO, step: delta_q};
    unique case (state)
      irprop_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt[irprop_pkg::INDEX_W-1:0];
        mem_wdata = '{sign: irprop_pkg::SIGN_ZERO, step: irprop_pkg::STEP_RESET};
        if (clr_cnt == irprop_pkg::CLR_W'(irprop_pkg::WEIGHT_COUNT - 1)) begin
          state_next = irprop_pkg::ST_IDLE;
        end
      end
      irprop_pkg::ST_IDLE: begin
        grad_stall = 1'b0;
        if (grad_valid) begin
          state_next = irprop_pkg::ST_MUL;
        end
      end
      irprop_pkg::ST_MUL: state_next = irprop_pkg::ST_RND;
      irprop_pkg::ST_RND: state_next = irprop_pkg::ST_UPD;
      irprop_pkg::ST_UPD: begin
        // hold here until the output register is free
        if (!upd_valid || !upd_stall) begin
          out_load   = 1'b1;
          mem_we     = in_range_q;
          mem_wdata.sign = gpos_q ? irprop_pkg::SIGN_POS :
                           (gneg_q ? irprop_pkg::SIGN_NEG : irprop_pkg::SIGN_ZERO);
          state_next = irprop_pkg::ST_IDLE;
        end
      end
      default: state_next = irprop_pkg::ST_CLEAR;
    endcase
  end

  // state memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_q <= mem[grad_beat.weight_index];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q     <= grad_beat;
      in_range_q <= {1'b0, grad_beat.weight_index} <
                    (irprop_pkg::INDEX_W+1)'(irprop_pkg::WEIGHT_COUNT);
    end
  end

  // multiply step: compare signs, pick factor
  logic g_zero, g_neg, p_pos, p_neg;
  irprop_pkg::step_op_t op_next;

  always_comb begin
    g_zero = (item_q.gradient == '0);
    g_neg  = item_q.gradient[31];
    p_pos  = (mem_q.sign == irprop_pkg::SIGN_POS);
    p_neg  = (mem_q.sign == irprop_pkg::SIGN_NEG);
    op_next = irprop_pkg::OP_KEEP;
    if (in_range_q && !g_zero) begin
      if ((p_pos && !g_neg) || (p_neg && g_neg)) begin
        op_next = irprop_pkg::OP_GROW;
      end else if (p_pos || p_neg) begin
        op_next = irprop_pkg::OP_SHRINK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == irprop_pkg::ST_MUL) begin
      op_q   <= op_next;
      gpos_q <= in_range_q && !g_zero && !g_neg && (op_next != irprop_pkg::OP_SHRINK);
      gneg_q <= in_range_q && g_neg && (op_next != irprop_pkg::OP_SHRINK);
      prod_q <= 48'(mem_q.step) *
                48'((op_next == irprop_pkg::OP_GROW) ? increase_factor : decrease_factor);
    end
  end

  // round half up, saturate to 32 bits, then cap or floor
  logic [48:0] rnd_sum;
  logic [34:0] rnd;
  logic [31:0] scaled;
  logic [31:0] delta_next;

  always_comb begin
    rnd_sum = {1'b0, prod_q} + irprop_pkg::ROUND_ADD;
    rnd     = rnd_sum[48:irprop_pkg::FRAC_W];
    scaled  = (|rnd[34:32]) ? '1 : rnd[31:0];
    case (op_q)
      irprop_pkg::OP_GROW:   delta_next = (scaled > step_ceiling) ? step_ceiling : scaled;
      irprop_pkg::OP_SHRINK: delta_next = (scaled < step_floor) ? step_floor : scaled;
      default:               delta_next = in_range_q ? mem_q.step : '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == irprop_pkg::ST_RND) begin
      delta_q <= delta_next;
    end
  end

  // weight move against the gradient sign, saturating
  logic signed [33:0] w_ext, d_ext, nw;
  logic signed [31:0] w_sat;

  always_comb begin
    w_ext = 34'(item_q.weight_in);
    d_ext = $signed({2'b00, delta_q});
    if (gpos_q) begin
      nw = w_ext - d_ext;
    end else if (gneg_q) begin
      nw = w_ext + d_ext;
    end else begin
      nw = w_ext;
    end
    if (nw[33:31] == 3'b000 || nw[33:31] == 3'b111) begin
      w_sat = nw[31:0];
    end else begin
      w_sat = nw[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid <= 1'b0;
    end else if (out_load) begin
      upd_valid <= 1'b1;
    end else if (!upd_stall) begin
      upd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      upd_beat.weight_out <= w_sat;
      upd_beat.step_used  <= delta_q;
    end
  end

  // checks
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> grad_stall)
    else $error("second item accepted while one is in flight");

  a_load_from_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(upd_valid) |-> $past(state) == irprop_pkg::ST_UPD)
    else $error("result appeared without an update step");

  a_shrink_clears_sign: assert property (@(posedge clk) disable iff (rst)
    (out_load && op_q == irprop_pkg::OP_SHRINK) |-> (!gpos_q && !gneg_q))
    else $error("sign kept after a step shrink");

  a_clear_bound: assert property (@(posedge clk) disable iff (rst)
    (state == irprop_pkg::ST_CLEAR) |->
      (clr_cnt < irprop_pkg::CLR_W'(irprop_pkg::WEIGHT_COUNT)))
    else $error("clearing pass ran past the memory");

  a_no_write_out_of_range: assert property (@(posedge clk) disable iff (rst)
    (state == irprop_pkg::ST_UPD && !in_range_q) |-> !mem_we)
    else $error("state written for an out-of-range index");

endmodule
